>>> rtl/core/vsgs_pkg.sv
// Package for the voxel stencil sweep: sizes, item kinds, payload types.
// No dependencies.
package vsgs_pkg;
  localparam int MaxDim = 16;
  localparam int MaxMaterials = 64;
  localparam int FracBits = 16;
  localparam int DimW = $clog2(MaxDim);
  localparam int VertW = 3 * DimW;
  localparam int NumVerts = MaxDim * MaxDim * MaxDim;
  localparam int SlotsPerMat = 246;
  localparam int InvBase = 234;
  localparam int ForceBase = 243;
  localparam int MatW = (MaxMaterials > 1) ? $clog2(MaxMaterials) : 1;
  localparam int CoefDepth = MaxMaterials * SlotsPerMat;
  localparam int CoefAw = $clog2(CoefDepth);

  localparam logic [1:0] KIND_WR_VERT = 2'd0;
  localparam logic [1:0] KIND_WR_COEF = 2'd1;
  localparam logic [1:0] KIND_SWEEP   = 2'd2;
  localparam logic [1:0] KIND_RD_VERT = 2'd3;

  localparam logic [1:0] REG_GRID_X = 2'd0;
  localparam logic [1:0] REG_GRID_Y = 2'd1;
  localparam logic [1:0] REG_GRID_Z = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [11:0]        vertex_index;
    logic [5:0]         material_id;
    logic               vertex_empty;
    logic [7:0]         coef_slot;
    logic signed [31:0] coef_value;
    logic signed [31:0] in_disp_x;
    logic signed [31:0] in_disp_y;
    logic signed [31:0] in_disp_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_disp_x;
    logic signed [31:0] out_disp_y;
    logic signed [31:0] out_disp_z;
    logic [5:0]         out_material;
    logic               out_empty;
    logic               sat_flag;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    logic [4:0] data;
  } cfg_word_t;

  // saturate a 64-bit sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic is_sat(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction
endpackage

>>> rtl/core/vsgs_if.sv
// Valid/ready channel interfaces for the sweep block.
// Depends on vsgs_pkg.
interface vsgs_in_if import vsgs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsgs_out_if import vsgs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsgs_cfg_if import vsgs_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/voxel_stencil_gauss_seidel_sweep.sv
// Top level of the voxel stencil sweep: sequencer, MAC and the two stores.
// Depends on vsgs_pkg, vsgs_if, vsgs_vert_mem, vsgs_coef_mem.
//
//  channel  dir  moves
//  in_ch    in   one command word (write/read vertex, write coefficient, sweep)
//  out_ch   out  one result word per command
//  cfg_ch   in   grid size register writes
//
// Writes pass through S_RDW to S_OUT; reads also pass through S_VCHK. A sweep
// reads each vertex centre (S_VLD, S_NADR); a non-empty vertex then takes S_NRD
// and S_MAC for each in-grid neighbour, skips the centre and each out-of-grid
// position in S_NADR, and solves in S_FRC, S_RHS, S_INV and S_WB, paced by the
// single coefficient memory port and one 32x32 multiplier. Empty vertices go
// to S_NEXT. Reset is synchronous and clears control only. out_ch stall holds
// the result; no new command is taken until it is delivered.
module voxel_stencil_gauss_seidel_sweep import vsgs_pkg::*; (
  input logic       clk,
  input logic       rst,
  vsgs_in_if.sink   in_ch,
  vsgs_out_if.source out_ch,
  vsgs_cfg_if.sink  cfg_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_RDW, S_VLD, S_VCHK, S_NADR, S_NRD, S_MAC, S_FRC, S_RHS,
    S_INV, S_WB, S_NEXT, S_OUT
  } state_t;

  state_t state;
  logic [DimW:0] nx, ny, nz;
  in_word_t cmd;
  out_word_t res;
  logic [DimW-1:0] x, y, z;
  logic [4:0] loc;
  logic [1:0] dz, dy, dx;
  logic [3:0] step;
  logic [MatW-1:0] mat;
  logic signed [31:0] nb [3];
  logic signed [63:0] acc [3];
  logic signed [31:0] rhs [3];
  logic sat;

  logic v_we, c_we;
  logic [VertW-1:0] v_addr;
  logic [3*32+6:0] v_wdata, v_rdata;
  logic [CoefAw-1:0] c_addr;
  logic [31:0] c_rdata;

  vsgs_vert_mem u_vert (.clk, .we(v_we), .addr(v_addr), .wdata(v_wdata),
                        .rdata(v_rdata));
  vsgs_coef_mem u_coef (.clk, .we(c_we), .addr(c_addr), .wdata(cmd.coef_value),
                        .rdata(c_rdata));

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = res;

  // neighbour coordinates (one below, same, one above)
  logic [DimW+1:0] ncx, ncy, ncz;
  logic n_in;
  assign ncx = {2'b0, x} + {{DimW{1'b0}}, dx} - 1'b1;
  assign ncy = {2'b0, y} + {{DimW{1'b0}}, dy} - 1'b1;
  assign ncz = {2'b0, z} + {{DimW{1'b0}}, dz} - 1'b1;
  assign n_in = (ncx < {1'b0, nx}) && (ncy < {1'b0, ny}) && (ncz < {1'b0, nz});

  // flat index helpers; narrow multiplies on grid sizes
  function automatic logic [VertW-1:0] flat(input logic [DimW+1:0] fx,
      input logic [DimW+1:0] fy, input logic [DimW+1:0] fz);
    logic [3*DimW+8:0] t;
    t = ({{(2*DimW+7){1'b0}}, fz} * ny + fy) * nx + fx;
    return t[VertW-1:0];
  endfunction

  // split a 3x3 entry number into quotient and remainder by three
  function automatic logic [3:0] div3(input logic [3:0] e);
    case (e)
      4'd0: return {2'd0, 2'd0};
      4'd1: return {2'd0, 2'd1};
      4'd2: return {2'd0, 2'd2};
      4'd3: return {2'd1, 2'd0};
      4'd4: return {2'd1, 2'd1};
      4'd5: return {2'd1, 2'd2};
      4'd6: return {2'd2, 2'd0};
      4'd7: return {2'd2, 2'd1};
      4'd8: return {2'd2, 2'd2};
      default: return 4'd0;
    endcase
  endfunction

  logic [4:0] kslot;
  assign kslot = (loc > 5'd13) ? loc - 5'd1 : loc;
  logic [CoefAw-1:0] mbase;
  assign mbase = CoefAw'(mat * SlotsPerMat);

  // entry whose coefficient is on c_rdata this cycle
  logic [3:0] e_qr;
  logic [1:0] e_quo, e_rem;
  assign e_qr  = div3(step - 4'd1);
  assign e_quo = e_qr[3:2];
  assign e_rem = e_qr[1:0];

  // one product, registered before the accumulate
  logic signed [63:0] prod, prod_q;
  logic [1:0] pr;
  logic pvalid;
  logic signed [31:0] mul_b;
  always_comb begin
    case (state)
      S_INV: mul_b = rhs[e_rem];
      default: mul_b = nb[e_quo];
    endcase
  end
  assign prod = $signed(c_rdata) * mul_b;

  // memory address and write control
  always_comb begin
    v_we = 1'b0;
    c_we = 1'b0;
    v_addr = flat({2'b0, x}, {2'b0, y}, {2'b0, z});
    v_wdata = {cmd.in_disp_x, cmd.in_disp_y, cmd.in_disp_z, cmd.vertex_empty,
               cmd.material_id};
    c_addr = CoefAw'(cmd.material_id * SlotsPerMat + cmd.coef_slot);
    case (state)
      S_RDW: begin
        v_addr = cmd.vertex_index[VertW-1:0];
        v_we = (cmd.kind == KIND_WR_VERT) && (cmd.vertex_index < NumVerts);
        c_we = (cmd.kind == KIND_WR_COEF) && (cmd.coef_slot < SlotsPerMat) &&
               ({2'b0, cmd.material_id} < MaxMaterials);
      end
      S_NADR, S_NRD: v_addr = flat(ncx, ncy, ncz);
      S_MAC: c_addr = mbase + CoefAw'(kslot * 9) + CoefAw'(step) ;
      S_FRC: c_addr = mbase + CoefAw'(ForceBase) + CoefAw'(step);
      S_INV: c_addr = mbase + CoefAw'(InvBase) + CoefAw'(step);
      S_WB: begin
        v_we = 1'b1;
        v_wdata = {rhs[0], rhs[1], rhs[2], 1'b0, 6'(mat)};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nx <= (DimW+1)'(16); ny <= (DimW+1)'(16); nz <= (DimW+1)'(16);
      pvalid <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.data.index)
          REG_GRID_X: nx <= (cfg_ch.data.data == 0) ? (DimW+1)'(1) :
              (cfg_ch.data.data > MaxDim) ? (DimW+1)'(MaxDim) : (DimW+1)'(cfg_ch.data.data);
          REG_GRID_Y: ny <= (cfg_ch.data.data == 0) ? (DimW+1)'(1) :
              (cfg_ch.data.data > MaxDim) ? (DimW+1)'(MaxDim) : (DimW+1)'(cfg_ch.data.data);
          REG_GRID_Z: nz <= (cfg_ch.data.data == 0) ? (DimW+1)'(1) :
              (cfg_ch.data.data > MaxDim) ? (DimW+1)'(MaxDim) : (DimW+1)'(cfg_ch.data.data);
          default: ;
        endcase
      end
      // register the product of the entry on c_rdata
      pvalid <= ((state == S_MAC) || (state == S_INV)) &&
                (step >= 4'd1) && (step <= 4'd9);
      pr <= (state == S_INV) ? e_quo : e_rem;
      prod_q <= prod >>> FracBits;
      // clear before each sum, else accumulate the registered product
      if ((state == S_NADR && step == 4'd0) || state == S_RHS) begin
        acc[0] <= '0; acc[1] <= '0; acc[2] <= '0;
      end else if (pvalid) begin
        acc[pr] <= acc[pr] + prod_q;
      end
      case (state)
        S_IDLE: if (in_ch.valid) begin
          cmd <= in_ch.data;
          res <= '0;
          x <= '0; y <= '0; z <= '0;
          sat <= 1'b0;
          step <= '0;
          state <= (in_ch.data.kind == KIND_SWEEP) ? S_VLD : S_RDW;
        end
        S_RDW: begin
          state <= (cmd.kind == KIND_RD_VERT) ? S_VCHK : S_OUT;
        end
        S_VCHK: begin
          // read data of vertex command
          if (cmd.vertex_index < NumVerts) begin
            res.out_disp_x <= v_rdata[102:71];
            res.out_disp_y <= v_rdata[70:39];
            res.out_disp_z <= v_rdata[38:7];
            res.out_empty <= v_rdata[6];
            res.out_material <= v_rdata[5:0];
          end
          state <= S_OUT;
        end
        S_VLD: state <= S_NADR;  // address of the centre vertex is presented
        S_NADR: begin
          if (step == 4'd0) begin
            // centre material now in v_rdata
            step <= 4'd1;
            mat <= MatW'(v_rdata[5:0]);
            if (v_rdata[6] || ({1'b0, v_rdata[5:0]} >= MaxMaterials)) begin
              state <= S_NEXT;
            end
            dz <= '0; dy <= '0; dx <= '0; loc <= '0;
          end else if (loc == 5'd13 || !n_in) begin
            // skip centre and out-of-grid neighbours
            dx <= (dx == 2) ? 2'd0 : dx + 2'd1;
            dy <= (dx == 2) ? ((dy == 2) ? 2'd0 : dy + 2'd1) : dy;
            dz <= (dx == 2 && dy == 2) ? dz + 2'd1 : dz;
            loc <= loc + 5'd1;
            if (loc == 5'd26) begin
              state <= S_FRC; step <= '0;
            end
          end else begin
            state <= S_NRD;
          end
        end
        S_NRD: begin
          nb[0] <= v_rdata[102:71];
          nb[1] <= v_rdata[70:39];
          nb[2] <= v_rdata[38:7];
          step <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          // slot c*3+r issued at step; its coefficient is registered by the coefficient memory
          if (step == 4'd9) begin
            dx <= (dx == 2) ? 2'd0 : dx + 2'd1;
            dy <= (dx == 2) ? ((dy == 2) ? 2'd0 : dy + 2'd1) : dy;
            dz <= (dx == 2 && dy == 2) ? dz + 2'd1 : dz;
            loc <= loc + 5'd1;
            if (loc == 5'd26) begin
              state <= S_FRC; step <= '0;
            end else begin
              state <= S_NADR; step <= 4'd1;
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        S_FRC: begin
          if (step == 4'd4) begin
            for (int r = 0; r < 3; r++) begin
              rhs[r] <= sat32(64'(rhs[r]) - acc[r]);
            end
            sat <= sat | is_sat(64'(rhs[0]) - acc[0]) | is_sat(64'(rhs[1]) - acc[1]) |
                   is_sat(64'(rhs[2]) - acc[2]);
            state <= S_RHS;
          end else begin
            step <= step + 4'd1;
            if (step != 4'd0)
              rhs[step[1:0]-2'd1] <= $signed(c_rdata);
          end
        end
        S_RHS: begin
          step <= '0;
          state <= S_INV;
        end
        S_INV: begin
          if (step == 4'd11) begin
            for (int r = 0; r < 3; r++) begin
              rhs[r] <= sat32(acc[r]);
            end
            sat <= sat | is_sat(acc[0]) | is_sat(acc[1]) | is_sat(acc[2]);
            state <= S_WB;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_WB: state <= S_NEXT;
        S_NEXT: begin
          step <= '0;
          if ({1'b0, x} == nx - 5'd1) begin
            x <= '0;
            if ({1'b0, y} == ny - 5'd1) begin
              y <= '0;
              if ({1'b0, z} == nz - 5'd1) begin
                res.sat_flag <= sat;
                state <= S_OUT;
              end else begin
                z <= z + 1'b1;
                state <= S_VLD;
              end
            end else begin
              y <= y + 1'b1;
              state <= S_VLD;
            end
          end else begin
            x <= x + 1'b1;
            state <= S_VLD;
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/vsgs_vert_mem.sv
// Vertex store: displacements and material marks, one port, registered read.
// Depends on vsgs_pkg.
module vsgs_vert_mem import vsgs_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [VertW-1:0]    addr,
  input  logic [3*32+6:0]     wdata,
  output logic [3*32+6:0]     rdata
);
  logic [3*32+6:0] mem [NumVerts];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/core/vsgs_coef_mem.sv
// Coefficient store: 246 Q16.16 words per material, registered read.
// Depends on vsgs_pkg.
module vsgs_coef_mem import vsgs_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [CoefAw-1:0]  addr,
  input  logic [31:0]        wdata,
  output logic [31:0]        rdata
);
  logic [31:0] mem [CoefDepth];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
